/* rtl/core/bdsm_pkg.sv */
// ----------------------------------------------------------------------------
// bdsm_pkg
// shared types and codes for the bounded descriptor set with min/max tracking
// ----------------------------------------------------------------------------
`default_nettype none

package bdsm_pkg;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// operation codes
	localparam logic FN_ADD = 1'b0;
	localparam logic FN_DEL = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture a new item, restart the scan
		logic step;    // issue one slot read
		logic fold;    // scan folds members into min/max instead of searching
		logic commit;  // apply the operation to the set
	} bdsm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;    // the slot being issued is the last one
		logic need_rescan;  // a member is removed, extremes must be rebuilt
	} bdsm_sts_t;

endpackage

`default_nettype wire

/* rtl/core/bdsm_ctrl.sv */
// ----------------------------------------------------------------------------
// bdsm_ctrl
// sequencer: search scan, commit, optional rescan of extremes, result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module bdsm_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire bdsm_pkg::bdsm_sts_t sts,
	output bdsm_pkg::bdsm_cmd_t     cmd,
	output logic                    busy,
	output logic                    done
);
	import bdsm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SEARCH_END,
		S_DECIDE,
		S_RESCAN,
		S_RESCAN_END,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	assign busy = busy_q;
	assign done = done_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.step   = (state_q == S_SEARCH) || (state_q == S_RESCAN);
		cmd.fold   = (state_q == S_RESCAN);
		cmd.commit = (state_q == S_DECIDE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SEARCH;
						busy_q  <= 1'b1;
					end
				end
				S_SEARCH: begin
					if (sts.scan_last) state_q <= S_SEARCH_END;
				end
				// last read still being evaluated
				S_SEARCH_END: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (sts.need_rescan) begin
						state_q <= S_RESCAN;
					end else begin
						state_q <= S_RESULT;
						done_q  <= 1'b1;
					end
				end
				S_RESCAN: begin
					if (sts.scan_last) state_q <= S_RESCAN_END;
				end
				S_RESCAN_END: begin
					state_q <= S_RESULT;
					done_q  <= 1'b1;
				end
				S_RESULT: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/bdsm_dp.sv */
// ----------------------------------------------------------------------------
// bdsm_dp
// slot memory, used bits, one-slot-per-cycle scan unit, count and extremes
// ----------------------------------------------------------------------------
`default_nettype none

module bdsm_dp #(
	parameter int CAPACITY = 32,
	parameter int LIMIT    = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bdsm_pkg::bdsm_cmd_t cmd,
	output bdsm_pkg::bdsm_sts_t      sts,
	input  wire logic                func,
	input  wire logic [10:0]         descriptor,
	output logic [1:0]               status,
	output logic [4:0]               slot_index,
	output logic                     was_present,
	output logic [5:0]               member_count,
	output logic [9:0]               min_member,
	output logic [9:0]               max_member,
	output logic                     extremes_valid
);
	import bdsm_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int VAL_W = $clog2(LIMIT);

	// slot storage
	logic [VAL_W-1:0]    mem [CAPACITY];
	logic [VAL_W-1:0]    rd_q;
	logic [CAPACITY-1:0] used_q;

	// item registers
	logic             func_q;
	logic [VAL_W-1:0] val_q;
	logic             range_bad_q;

	// scan unit
	logic [IDX_W-1:0] idx_q;
	logic             valid_s1;
	logic             fold_s1;
	logic             used_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	// set state
	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] min_q;
	logic [VAL_W-1:0] max_q;
	logic             ok_q;

	// result
	logic [1:0]       status_q;
	logic [IDX_W-1:0] slot_q;
	logic             present_q;

	logic             add_new;
	logic             mem_we;
	logic [31:0]      slot_ext;
	logic [31:0]      cnt_ext;
	logic [15:0]      min_ext;
	logic [15:0]      max_ext;

	assign add_new = (func_q == FN_ADD) && !range_bad_q && !found_q && free_q;
	assign mem_we  = cmd.commit && add_new;

	assign sts.scan_last   = (idx_q == IDX_W'(CAPACITY - 1));
	assign sts.need_rescan = (func_q == FN_DEL) && !range_bad_q && found_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[free_idx_q] <= val_q;
		rd_q <= mem[idx_q];
	end

	// item capture and read pipeline tags
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q      <= func;
			val_q       <= descriptor[VAL_W-1:0];
			range_bad_q <= ({1'b0, descriptor} >= 12'(LIMIT));
		end
		fold_s1 <= cmd.fold;
		used_s1 <= used_q[idx_q];
		idx_s1  <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			used_q      <= '0;
			count_q     <= '0;
			min_q       <= '0;
			max_q       <= '0;
			ok_q        <= 1'b0;
		end else begin
			valid_s1 <= cmd.step;
			if (cmd.load || cmd.commit) begin
				idx_q <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_q + IDX_W'(1);
			end

			if (cmd.load) begin
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end

			// evaluate the slot read issued last cycle
			if (valid_s1 && used_s1) begin
				if (fold_s1) begin
					if (!ok_q) begin
						min_q <= rd_q;
						max_q <= rd_q;
						ok_q  <= 1'b1;
					end else begin
						if (rd_q < min_q) min_q <= rd_q;
						if (rd_q > max_q) max_q <= rd_q;
					end
				end else if (!found_q && rd_q == val_q) begin
					found_q     <= 1'b1;
					found_idx_q <= idx_s1;
				end
			end else if (valid_s1 && !fold_s1 && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end

			if (cmd.commit) begin
				if (add_new) begin
					used_q[free_idx_q] <= 1'b1;
					count_q            <= count_q + CNT_W'(1);
					if (!ok_q) begin
						min_q <= val_q;
						max_q <= val_q;
						ok_q  <= 1'b1;
					end else begin
						if (val_q < min_q) min_q <= val_q;
						if (val_q > max_q) max_q <= val_q;
					end
				end else if (sts.need_rescan) begin
					used_q[found_idx_q] <= 1'b0;
					if (count_q != '0) count_q <= count_q - CNT_W'(1);
					// extremes rebuilt by the fold scan that follows
					min_q <= '0;
					max_q <= '0;
					ok_q  <= 1'b0;
				end
			end
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			present_q <= found_q && !range_bad_q;
			if (range_bad_q) begin
				status_q <= ST_RANGE;
				slot_q   <= '0;
			end else if (found_q) begin
				status_q <= ST_OK;
				slot_q   <= found_idx_q;
			end else if (func_q == FN_DEL) begin
				status_q <= ST_OK;
				slot_q   <= '0;
			end else if (free_q) begin
				status_q <= ST_OK;
				slot_q   <= free_idx_q;
			end else begin
				status_q <= ST_FULL;
				slot_q   <= '0;
			end
		end
	end

	assign slot_ext = 32'(slot_q);
	assign cnt_ext  = 32'(count_q);
	assign min_ext  = ok_q ? 16'(min_q) : 16'd0;
	assign max_ext  = ok_q ? 16'(max_q) : 16'd0;

	assign status         = status_q;
	assign slot_index     = slot_ext[4:0];
	assign was_present    = present_q;
	assign member_count   = cnt_ext[5:0];
	assign min_member     = min_ext[9:0];
	assign max_member     = max_ext[9:0];
	assign extremes_valid = ok_q;

endmodule

`default_nettype wire

/* rtl/core/bounded_descriptor_set_minmax.sv */
// ----------------------------------------------------------------------------
// bounded_descriptor_set_minmax
// fixed-capacity descriptor set with running min/max member
// ----------------------------------------------------------------------------
// usage:
//   command channel: drive func/descriptor and raise start while busy is low;
//   the command transfers at that edge and busy rises on the next cycle.
//   result channel: done is high for exactly one cycle with status,
//   slot_index, was_present, member_count, min/max and extremes_valid.
//   there is no backpressure; the receiver must take the result then.
// sequencing:
//   add, rejected or absent delete: one search pass over the slot memory
//   at one slot per cycle, a state to finish the last read, one to commit.
//   delete of a member: after the commit, a second pass over the slots
//   rebuilds min and max, then a state to finish its last read. busy drops
//   in the cycle after done, so a new command transfers only once the
//   previous result has been delivered.
// reset:
//   arst_n clears all used bits, the count and the extremes at once; the
//   slot memory itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_descriptor_set_minmax #(
	parameter int CAPACITY = 32,
	parameter int LIMIT    = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [10:0] descriptor,
	output logic             done,
	output logic [1:0]       status,
	output logic [4:0]       slot_index,
	output logic             was_present,
	output logic [5:0]       member_count,
	output logic [9:0]       min_member,
	output logic [9:0]       max_member,
	output logic             extremes_valid
);
	import bdsm_pkg::*;

	bdsm_cmd_t cmd;
	bdsm_sts_t sts;

	bdsm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	bdsm_dp #(
		.CAPACITY(CAPACITY),
		.LIMIT   (LIMIT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.descriptor    (descriptor),
		.status        (status),
		.slot_index    (slot_index),
		.was_present   (was_present),
		.member_count  (member_count),
		.min_member    (min_member),
		.max_member    (max_member),
		.extremes_valid(extremes_valid)
	);

endmodule

`default_nettype wire

/* rtl/core/bdsm_checker.sv */
// ----------------------------------------------------------------------------
// bdsm_checker
// port-level checks on the command/result sequencing of the descriptor set
// ----------------------------------------------------------------------------
`default_nettype none

module bdsm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [9:0]  min_member,
	input wire logic [9:0]  max_member,
	input wire logic        extremes_valid
);
	import bdsm_pkg::*;

	// a result only appears for a command in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command transfer did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_RANGE || status == ST_FULL))
		else $error("undefined status code");

	a_empty_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		done && !extremes_valid |-> min_member == '0 && max_member == '0)
		else $error("extremes nonzero on empty set");

endmodule

bind bounded_descriptor_set_minmax bdsm_checker u_bdsm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.min_member    (min_member),
	.max_member    (max_member),
	.extremes_valid(extremes_valid)
);

`default_nettype wire

/* tb/bounded_descriptor_set_minmax_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_descriptor_set_minmax_tb
// self-checking bench for the fixed-capacity descriptor set with min/max
// ----------------------------------------------------------------------------
// a short table of directed commands (empty set, range rejects, first and
// last descriptors, fill to full, extremes removed) is followed by random
// add/delete traffic that swings the set between empty and full. every
// transfer is run through a local model of the set and each done strobe is
// compared field by field against the oldest pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_descriptor_set_minmax_tb;

	import bdsm_pkg::*;

	localparam int CAP         = 32;
	localparam int LIM         = 1024;
	localparam int RAND_ITEMS  = 1000;
	localparam int PHASE_LEN   = 350;
	localparam int DRAIN_WAIT  = 2 * CAP + 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] slot;
		logic       present;
		logic [5:0] count;
		logic [9:0] lo;
		logic [9:0] hi;
		logic       ext_ok;
	} set_result_t;

	typedef struct {
		logic        op;
		logic [10:0] desc;
		int          reps;
		int          stride;
		bit          typed;
		set_result_t exp;
	} cmd_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        func;
	logic [10:0] descriptor;
	logic        done;
	logic [1:0]  status;
	logic [4:0]  slot_index;
	logic        was_present;
	logic [5:0]  member_count;
	logic [9:0]  min_member;
	logic [9:0]  max_member;
	logic        extremes_valid;

	bounded_descriptor_set_minmax #(
		.CAPACITY(CAP),
		.LIMIT(LIM)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.descriptor(descriptor),
		.done(done),
		.status(status),
		.slot_index(slot_index),
		.was_present(was_present),
		.member_count(member_count),
		.min_member(min_member),
		.max_member(max_member),
		.extremes_valid(extremes_valid)
	);

	// model of the set
	logic [9:0]  set_vals [CAP];
	bit          set_taken [CAP];
	int          set_size;
	logic [9:0]  set_lo;
	logic [9:0]  set_hi;
	bit          set_ext_ok;

	set_result_t pending_results [$];
	cmd_row_t    cmd_rows [$];

	logic        cur_op;
	logic [10:0] cur_desc;
	bit          cur_typed;
	set_result_t cur_exp;
	int          row_idx;
	int          rep_idx;
	bit          filling;

	int          err_count;
	int          results_seen;
	int          cycles;
	int          n_add, n_del, n_range, n_full, n_emptied;

	set_result_t seen;
	set_result_t want;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic set_result_t mk_result(logic [1:0] st, int sl, bit pr, int cnt,
	                                          int mn, int mx, bit ev);
		set_result_t r;
		r.status  = st;
		r.slot    = 5'(sl);
		r.present = pr;
		r.count   = 6'(cnt);
		r.lo      = 10'(mn);
		r.hi      = 10'(mx);
		r.ext_ok  = ev;
		return r;
	endfunction

	function automatic string fmt_result(set_result_t r);
		return $sformatf("st=%0d slot=%0d pres=%0d cnt=%0d min=%0d max=%0d ev=%0d",
		                 r.status, r.slot, r.present, r.count, r.lo, r.hi, r.ext_ok);
	endfunction

	function automatic void fold_member(logic [9:0] v);
		if (!set_ext_ok) begin
			set_lo = v;
			set_hi = v;
			set_ext_ok = 1'b1;
		end else begin
			if (v < set_lo) set_lo = v;
			if (v > set_hi) set_hi = v;
		end
	endfunction

	function automatic set_result_t apply_set_op(logic op, logic [10:0] d);
		set_result_t r;
		int hit;
		int hole;
		r = '0;
		hit = -1;
		hole = -1;
		if (d >= LIM) begin
			r.status = ST_RANGE;
			n_range++;
		end else begin
			for (int i = 0; i < CAP; i++) begin
				if (set_taken[i]) begin
					if (hit < 0 && set_vals[i] == d[9:0]) hit = i;
				end else if (hole < 0) begin
					hole = i;
				end
			end
			r.present = (hit >= 0);
			if (op == FN_ADD) begin
				n_add++;
				if (hit >= 0) begin
					r.slot = 5'(hit);
				end else if (hole >= 0) begin
					set_vals[hole] = d[9:0];
					set_taken[hole] = 1'b1;
					set_size++;
					fold_member(d[9:0]);
					r.slot = 5'(hole);
				end else begin
					r.status = ST_FULL;
					n_full++;
				end
			end else begin
				n_del++;
				if (hit >= 0) begin
					set_taken[hit] = 1'b0;
					set_size--;
					// rebuild extremes from what is left
					set_lo = '0;
					set_hi = '0;
					set_ext_ok = 1'b0;
					for (int i = 0; i < CAP; i++)
						if (set_taken[i]) fold_member(set_vals[i]);
					if (set_size == 0) n_emptied++;
					r.slot = 5'(hit);
				end
			end
		end
		r.count  = 6'(set_size);
		r.lo     = set_ext_ok ? set_lo : 10'd0;
		r.hi     = set_ext_ok ? set_hi : 10'd0;
		r.ext_ok = set_ext_ok;
		return r;
	endfunction

	task automatic add_row(logic op, int d, int reps, int stride, bit typed, set_result_t exp);
		cmd_row_t row;
		row.op     = op;
		row.desc   = 11'(d);
		row.reps   = reps;
		row.stride = stride;
		row.typed  = typed;
		row.exp    = exp;
		cmd_rows.push_back(row);
	endtask

	function automatic logic [10:0] pick_descriptor();
		case ($urandom_range(9))
			0:       return 11'd0;
			1:       return 11'(LIM - 1);
			2, 3:    return 11'($urandom_range(15));
			default: return 11'($urandom_range(LIM - 1));
		endcase
	endfunction

	function automatic logic [10:0] pick_member();
		int k;
		k = $urandom_range(CAP - 1);
		for (int i = 0; i < CAP; i++)
			if (set_taken[(k + i) % CAP]) return {1'b0, set_vals[(k + i) % CAP]};
		return 11'd0;
	endfunction

	task automatic load_next_item();
		int r;
		cmd_row_t row;
		if (row_idx < cmd_rows.size()) begin
			row = cmd_rows[row_idx];
			cur_op    = row.op;
			cur_desc  = 11'(row.desc + rep_idx * row.stride);
			cur_typed = row.typed;
			cur_exp   = row.exp;
			rep_idx++;
			if (rep_idx == row.reps) begin
				row_idx++;
				rep_idx = 0;
			end
		end else begin
			cur_typed = 1'b0;
			// swing between filling and draining so both full and empty recur
			if (set_size == CAP) filling = 1'b0;
			else if (set_size == 0) filling = 1'b1;
			r = $urandom_range(99);
			if (r < 8) begin
				cur_op   = 1'($urandom_range(1));
				cur_desc = 11'($urandom_range(2047, LIM));
			end else if (r < 13) begin
				cur_op   = 1'($urandom_range(1));
				cur_desc = 11'($urandom_range(2047));
			end else if (set_size != 0 && r < (filling ? 25 : 55)) begin
				cur_op   = FN_DEL;
				cur_desc = pick_member();
			end else if (set_size != 0 && r < (filling ? 33 : 63)) begin
				cur_op   = FN_ADD;
				cur_desc = pick_member();
			end else if (r < (filling ? 38 : 75)) begin
				cur_op   = FN_DEL;
				cur_desc = pick_descriptor();
			end else begin
				cur_op   = FN_ADD;
				cur_desc = pick_descriptor();
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (done === 1'b1) begin
			seen = {status, slot_index, was_present, member_count,
			        min_member, max_member, extremes_valid};
			results_seen++;
			if (pending_results.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result: %s", fmt_result(seen));
			end else begin
				want = pending_results.pop_front();
				if (seen !== want) begin
					err_count++;
					if (err_count <= 10) begin
						$display("mismatch at result %0d", results_seen);
						$display("  expected %s", fmt_result(want));
						$display("  actual   %s", fmt_result(seen));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int dir_items;
		int total;
		int issued;
		int idle_pct;
		bit took;
		bit at_pause;
		set_result_t pred;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_ADD;
		descriptor = '0;
		err_count = 0;
		results_seen = 0;
		cycles = 0;
		n_add = 0;
		n_del = 0;
		n_range = 0;
		n_full = 0;
		n_emptied = 0;
		row_idx = 0;
		rep_idx = 0;
		filling = 1'b0;
		set_size = 0;
		set_lo = '0;
		set_hi = '0;
		set_ext_ok = 1'b0;
		for (int i = 0; i < CAP; i++) begin
			set_vals[i] = '0;
			set_taken[i] = 1'b0;
		end

		add_row(FN_DEL, 5,    1, 0, 1, mk_result(ST_OK,    0, 0, 0, 0, 0, 0));
		add_row(FN_ADD, 2047, 1, 0, 1, mk_result(ST_RANGE, 0, 0, 0, 0, 0, 0));
		add_row(FN_DEL, 1024, 1, 0, 1, mk_result(ST_RANGE, 0, 0, 0, 0, 0, 0));
		add_row(FN_ADD, 0,    1, 0, 1, mk_result(ST_OK,    0, 0, 1, 0, 0, 1));
		add_row(FN_ADD, 1023, 1, 0, 1, mk_result(ST_OK,    1, 0, 2, 0, 1023, 1));
		add_row(FN_ADD, 0,    1, 0, 1, mk_result(ST_OK,    0, 1, 2, 0, 1023, 1));
		add_row(FN_DEL, 0,    1, 0, 1, mk_result(ST_OK,    0, 1, 1, 1023, 1023, 1));
		add_row(FN_ADD, 512,  1, 0, 0, '0);
		add_row(FN_DEL, 1023, 1, 0, 0, '0);
		add_row(FN_DEL, 512,  1, 0, 0, '0);
		// empty set, fill all slots with 300..455
		add_row(FN_ADD, 300,  CAP, 5, 0, '0);
		add_row(FN_ADD, 1000, 1, 0, 1, mk_result(ST_FULL,  0, 0, 32, 300, 455, 1));
		add_row(FN_ADD, 455,  1, 0, 0, '0);
		add_row(FN_ADD, 1024, 1, 0, 0, '0);
		add_row(FN_DEL, 300,  1, 0, 0, '0);
		add_row(FN_DEL, 455,  1, 0, 0, '0);
		add_row(FN_ADD, 7,    1, 0, 0, '0);
		add_row(FN_DEL, 999,  1, 0, 0, '0);
		add_row(FN_ADD, 1023, 1, 0, 0, '0);

		dir_items = 0;
		foreach (cmd_rows[i]) dir_items += cmd_rows[i].reps;
		total = dir_items + RAND_ITEMS;
		issued = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (issued < total || start) begin
			@(posedge clk);
			took = start && !busy;
			if (took) begin
				pred = apply_set_op(cur_op, cur_desc);
				pending_results.push_back(cur_typed ? cur_exp : pred);
				issued++;
			end
			if (issued < dir_items + PHASE_LEN) idle_pct = 20;
			else if (issued < dir_items + 2 * PHASE_LEN) idle_pct = 63;
			else idle_pct = 0;
			// hold off at phase boundaries until the set has gone quiet
			at_pause = (issued == dir_items || issued == dir_items + PHASE_LEN ||
			            issued == dir_items + 2 * PHASE_LEN) &&
			           (pending_results.size() != 0 || busy);
			if (start && !took) begin
				// command still waiting for its transfer
			end else if (issued == total || at_pause ||
			             $urandom_range(99) < idle_pct) begin
				start <= 1'b0;
			end else begin
				load_next_item();
				start <= 1'b1;
				func <= cur_op;
				descriptor <= cur_desc;
			end
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d commands, %0d results checked: %0d adds, %0d deletes",
		         issued, results_seen, n_add, n_del);
		$display("%0d out of range, %0d set full, %0d times emptied by delete",
		         n_range, n_full, n_emptied);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", err_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
